[src/cdr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdr_pkg
// Shared types and constants of the cubic Doppler resampler.
// ----------------------------------------------------------------------------
package cdr_pkg;

    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int PHASE_FRAC_BITS_DEF = 16;

    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_PHASE_STEP = 1'b0;

    typedef enum logic [1:0] {
        TERM_A0,
        TERM_A1,
        TERM_A2,
        TERM_A3
    } term_t;

    typedef struct packed {
        logic  capture;
        logic  shift;
        logic  add_step;
        logic  load_acc;
        logic  mul;
        logic  add;
        term_t sel;
        logic  last;
    } cmd_t;

    typedef struct packed {
        logic phase_lt_one;
        logic sum_lt_one;
        logic out_free;
    } sts_t;

endpackage

[src/cdr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdr_ctrl
// Sequencer: runs the phase loops and steps the shared multiplier through
// the three Horner terms of each interpolated sample.
// ----------------------------------------------------------------------------
module cdr_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cdr_pkg::sts_t  sts,
    output cdr_pkg::cmd_t  cmd
);
    import cdr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_SHIFT,
        ST_CHECK,
        ST_LOAD,
        ST_MUL,
        ST_ADD
    } state_t;

    state_t state_reg;
    term_t  term_reg;
    logic   pre_reg;
    logic   s_ready_reg;
    logic   final_term;

    assign s_ready    = s_ready_reg;
    assign final_term = (term_reg == TERM_A3);

    always_comb begin
        cmd          = '0;
        cmd.sel      = term_reg;
        cmd.last     = !pre_reg && !sts.sum_lt_one;
        cmd.capture  = (state_reg == ST_IDLE) && s_valid && s_ready_reg;
        cmd.shift    = (state_reg == ST_SHIFT);
        cmd.load_acc = (state_reg == ST_LOAD);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.add      = (state_reg == ST_ADD) && (!final_term || sts.out_free);
        cmd.add_step = (state_reg == ST_PRE) ||
                       ((state_reg == ST_ADD) && final_term && sts.out_free && !pre_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            term_reg    <= TERM_A1;
            pre_reg     <= 1'b0;
            s_ready_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (!s_ready_reg) begin
                        s_ready_reg <= 1'b1;
                    end else if (s_valid) begin
                        s_ready_reg <= 1'b0;
                        pre_reg     <= sts.phase_lt_one;
                        state_reg   <= sts.phase_lt_one ? ST_PRE : ST_SHIFT;
                    end
                end
                ST_PRE: begin
                    if (sts.sum_lt_one) begin
                        state_reg <= ST_LOAD;
                    end else begin
                        pre_reg   <= 1'b0;
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (sts.phase_lt_one) begin
                        state_reg <= ST_LOAD;
                    end else begin
                        s_ready_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_LOAD: begin
                    term_reg  <= TERM_A1;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    if (!final_term) begin
                        term_reg  <= term_t'(term_reg + 2'd1);
                        state_reg <= ST_MUL;
                    end else if (sts.out_free) begin
                        state_reg <= pre_reg ? ST_PRE : ST_CHECK;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[src/cdr_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdr_dpath
// History, phase accumulator, Horner multiply-add unit and output register.
// ----------------------------------------------------------------------------
module cdr_dpath #(
    parameter int SAMPLE_BITS     = cdr_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_FRAC_BITS = cdr_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cdr_pkg::cmd_t                 cmd,
    output cdr_pkg::sts_t                 sts,
    input  logic [PHASE_FRAC_BITS+1:0]    phase_step,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic                          m_last_out
);
    import cdr_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int PF = PHASE_FRAC_BITS;
    localparam int HW = SB + 4;
    localparam int PW = PF + 3;
    localparam int MW = HW + PF + 1;

    localparam logic [PW-1:0]        PH_ONE   = {3'b001, {PF{1'b0}}};
    localparam logic signed [MW-1:0] RND_HALF = {{(HW+2){1'b0}}, {(PF-1){1'b0}}} |
                                                (MW'(1) << (PF - 1));
    localparam logic signed [HW-1:0] SAT_MAX  = {{(HW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [HW-1:0] SAT_MIN  = {{(HW-SB+1){1'b1}}, {(SB-1){1'b0}}};

    logic signed [SB-1:0] hist_reg [4];
    logic signed [SB-1:0] sample_reg;
    logic [PW-1:0]        phase_reg;
    logic [PW-1:0]        phase_sum;
    logic signed [HW-1:0] acc_reg;
    logic signed [MW-1:0] prod_reg;
    logic signed [MW-1:0] prod_next;
    logic signed [MW-1:0] rnd_full;
    logic signed [HW-1:0] rnd;
    logic signed [HW-1:0] b0, b1, b2, b3;
    logic signed [HW-1:0] a0, a1, a2, a3;
    logic signed [HW-1:0] coef;
    logic signed [HW-1:0] sum;
    logic signed [HW-1:0] sat;
    logic                 m_valid_reg;
    logic signed [SB-1:0] sample_out_reg;
    logic                 last_reg;

    assign b0 = HW'(hist_reg[0]);
    assign b1 = HW'(hist_reg[1]);
    assign b2 = HW'(hist_reg[2]);
    assign b3 = HW'(hist_reg[3]);
    assign a0 = b3 - b2 - b0 + b1;
    assign a1 = b0 - b1 - a0;
    assign a2 = b2 - b0;
    assign a3 = b1;

    always_comb begin
        case (cmd.sel)
            TERM_A0: coef = a0;
            TERM_A1: coef = a1;
            TERM_A2: coef = a2;
            TERM_A3: coef = a3;
            default: coef = a0;
        endcase
    end

    assign phase_sum = phase_reg + {1'b0, phase_step};
    assign prod_next = acc_reg * $signed({1'b0, phase_reg[PF-1:0]});
    assign rnd_full  = prod_reg + RND_HALF;
    assign rnd       = rnd_full[HW+PF-1:PF];
    assign sum       = coef + rnd;

    always_comb begin
        if (sum > SAT_MAX) begin
            sat = SAT_MAX;
        end else if (sum < SAT_MIN) begin
            sat = SAT_MIN;
        end else begin
            sat = sum;
        end
    end

    assign sts.phase_lt_one = (phase_reg < PH_ONE);
    assign sts.sum_lt_one   = (phase_sum < PH_ONE);
    assign sts.out_free     = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                hist_reg[i] <= '0;
            end
            phase_reg <= '0;
        end else begin
            if (cmd.shift) begin
                hist_reg[0] <= hist_reg[1];
                hist_reg[1] <= hist_reg[2];
                hist_reg[2] <= hist_reg[3];
                hist_reg[3] <= sample_reg;
                phase_reg   <= phase_reg - PH_ONE;
            end else if (cmd.add_step) begin
                phase_reg <= phase_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_sample_in;
        end
        if (cmd.load_acc) begin
            acc_reg <= a0;
        end else if (cmd.add && cmd.sel != TERM_A3) begin
            acc_reg <= sum;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.add && cmd.sel == TERM_A3) begin
            sample_out_reg <= sat[SB-1:0];
            last_reg       <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.add && cmd.sel == TERM_A3) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = sample_out_reg;
    assign m_last_out   = last_reg;

endmodule

[src/cubic_doppler_resampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_doppler_resampler
// Four-point cubic fractional resampler with an APB phase step register.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_sample_in
//  m_        out        m_valid/m_ready    m_sample_out, m_last_out
//  apb       in         psel/penable       paddr, pwdata -> prdata
//
// Each result takes a phase check or step, a coefficient load and three
// multiply/add passes through the single shared multiplier. An item adds an
// accept, a history shift and a final phase check; the first item after reset
// adds a phase step that ends the pre-roll. Reset is synchronous and clears
// history and phase. A stalled result holds the last Horner add.
// ----------------------------------------------------------------------------
module cubic_doppler_resampler #(
    parameter int SAMPLE_BITS     = cdr_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_FRAC_BITS = cdr_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic                          m_last_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cdr_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import cdr_pkg::*;

    localparam int PF = PHASE_FRAC_BITS;
    localparam int SW = PF + 2;

    localparam logic [SW-1:0] STEP_MIN   = {7'b0000001, {(PF-5){1'b0}}};
    localparam logic [SW-1:0] STEP_RESET = {2'b01, {PF{1'b0}}};

    logic [SW-1:0] step_reg;
    logic [SW-1:0] step_next;
    logic          reg_sel;
    logic          wr_en;
    cmd_t          cmd;
    sts_t          sts;

    assign pready    = 1'b1;
    assign reg_sel   = (paddr[ADDR_W-1:2] == REG_PHASE_STEP);
    assign wr_en     = psel && penable && pwrite && pready && reg_sel;
    assign step_next = (pwdata[SW-1:0] < STEP_MIN) ? STEP_MIN : pwdata[SW-1:0];
    assign prdata    = reg_sel ? {{(32-SW){1'b0}}, step_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RESET;
        end else if (wr_en) begin
            step_reg <= step_next;
        end
    end

    cdr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cdr_dpath #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .phase_step   (step_reg),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_last_out   (m_last_out)
    );

    a_step_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg >= STEP_MIN)
        else $error("phase step below floor");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.add && cmd.sel == TERM_A3) |-> (!m_valid || m_ready))
        else $error("result loaded over a pending transaction");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted during processing");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.mul || cmd.add || cmd.shift || cmd.add_step))
        else $error("datapath active while accepting input");

endmodule
